FILE: hdl/tprs_pkg.sv
package tprs_pkg;

    localparam int NUM_PAGES = 6;
    localparam int SLOT_W    = 3;
    localparam int DWELL_W   = 8;
    localparam int TPS_W     = 16;
    localparam int TICK_W    = 24;
    localparam int TABLE_W   = 48;
    localparam int CFG_ADDR_W = 1;

    localparam logic [TABLE_W-1:0]   DWELL_RESET = 48'h05050F0A0A0A;
    localparam logic [TPS_W-1:0]     TPS_RESET   = 16'd1000;
    localparam logic [NUM_PAGES-1:0] MASK_RESET  = 6'b001111;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SKIP   = 2'd1,
        OP_SELECT = 2'd2,
        OP_ENABLE = 2'd3
    } op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DWELL = 1'b0,
        REG_TPS   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic              start;
        logic [SLOT_W-1:0] slot;
    } scan_req_t;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] slot;
    } scan_rsp_t;

    function automatic logic [DWELL_W-1:0] dwell_of(input logic [TABLE_W-1:0] tbl,
                                                    input logic [SLOT_W-1:0] slot);
        logic [DWELL_W-1:0] d;
        d = '0;
        for (int i = 0; i < 6; i++) begin
            if (slot == SLOT_W'(i)) begin
                d = tbl[i*DWELL_W +: DWELL_W];
            end
        end
        return d;
    endfunction

endpackage

FILE: hdl/tprs_scan.sv
module tprs_scan
    import tprs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  scan_req_t            req,
    input  logic [NUM_PAGES-1:0] mask,
    output scan_rsp_t            rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [SLOT_W-1:0] cand_reg;
    logic [SLOT_W-1:0] cnt_reg;
    logic [SLOT_W-1:0] cand_next;
    logic              hit;

    // one candidate slot per cycle, round-robin
    assign cand_next = (cand_reg == SLOT_W'(NUM_PAGES - 1)) ? '0 : cand_reg + 1'b1;
    assign hit       = mask[cand_next] || (cnt_reg == SLOT_W'(NUM_PAGES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && hit) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            cand_reg <= req.slot;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cand_reg <= cand_next;
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.slot = cand_reg;

endmodule

FILE: hdl/timed_page_rotation_scheduler_top.sv
// Timed page rotation scheduler.
// Input channel s_*: one request per accepted beat; s_tuser carries the
// operation (tick, skip, select, enable), s_tdata the page and enable flag.
// Output channel m_*: exactly one result per request, current page and a
// flag set when the page moved or the dwell counter was cleared.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr
// (0 dwell table, 1 ticks per second) on the same edge; write only when idle.
// Select and enable pass through the execute and output states; ticks that
// do not expire also pass the compare state. When the next enabled page is
// searched (skip, disabling the shown page, expired tick) the shared scan
// unit checks one slot per cycle, at most 6 slots.
// One request is in flight at a time; s_tready is low from accept until the
// result is loaded into the output register. If the receiver stalls, the
// result waits in the output register and the next request may be taken,
// but its result is held back until the previous one is taken.
// Reset: page 0 shown, pages 0 to 3 enabled, counter zero, default dwell
// table and 1000 ticks per second; no output pending.
module timed_page_rotation_scheduler_top
    import tprs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [2:0] page, [3] enable_value
    input  logic [1:0]            s_tuser,   // [1:0] op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [2:0] current_page, [3] page_changed
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [TABLE_W-1:0]    cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_CMP  = 5'b00100,
        S_SCAN = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [TABLE_W-1:0]   dwell_reg;
    logic [TPS_W-1:0]     tps_reg;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [NUM_PAGES-1:0] mask_reg, mask_next;
    logic [TICK_W-1:0]    elapsed_reg, elapsed_next;
    logic [TICK_W-1:0]    limit_reg, limit_next;
    logic                 changed_reg, changed_next;
    op_t                  op_reg;
    logic [SLOT_W-1:0]    page_reg;
    logic                 en_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [7:0]           m_tdata_reg, m_tdata_next;
    logic                 page_ok;
    scan_req_t            scan_req;
    scan_rsp_t            scan_rsp;

    tprs_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (scan_req),
        .mask    (mask_reg),
        .rsp     (scan_rsp)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign page_ok  = (page_reg < SLOT_W'(NUM_PAGES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dwell_reg <= DWELL_RESET;
            tps_reg   <= TPS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_DWELL: dwell_reg <= cfg_wdata;
                REG_TPS:   tps_reg   <= cfg_wdata[TPS_W-1:0];
                default:   dwell_reg <= dwell_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg   <= op_t'(s_tuser);
            page_reg <= s_tdata[2:0];
            en_reg   <= s_tdata[3];
        end
        limit_reg   <= limit_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            slot_reg     <= '0;
            mask_reg     <= MASK_RESET;
            elapsed_reg  <= '0;
            changed_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            mask_reg     <= mask_next;
            elapsed_reg  <= elapsed_next;
            changed_reg  <= changed_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        mask_next     = mask_reg;
        elapsed_next  = elapsed_reg;
        limit_next    = limit_reg;
        changed_next  = changed_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        scan_req      = '{start: 1'b0, slot: slot_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    changed_next = 1'b0;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (op_reg)
                    OP_TICK: begin
                        limit_next = TICK_W'(dwell_of(dwell_reg, slot_reg) * tps_reg);
                        if (elapsed_reg != '1) begin
                            elapsed_next = elapsed_reg + 1'b1;
                        end
                        state_next = S_CMP;
                    end
                    OP_SKIP: begin
                        scan_req.start = 1'b1;
                        changed_next   = 1'b1;
                        state_next     = S_SCAN;
                    end
                    OP_SELECT: begin
                        if (page_ok) begin
                            slot_next    = page_reg;
                            elapsed_next = '0;
                            changed_next = 1'b1;
                        end
                        state_next = S_OUT;
                    end
                    OP_ENABLE: begin
                        state_next = S_OUT;
                        if (page_ok) begin
                            mask_next[page_reg] = en_reg;
                            if (!en_reg && page_reg == slot_reg) begin
                                scan_req.start = 1'b1;
                                changed_next   = 1'b1;
                                state_next     = S_SCAN;
                            end
                        end
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_CMP: begin
                if (elapsed_reg >= limit_reg) begin
                    scan_req.start = 1'b1;
                    changed_next   = 1'b1;
                    state_next     = S_SCAN;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_SCAN: begin
                if (scan_rsp.done) begin
                    slot_next    = scan_rsp.slot;
                    elapsed_next = '0;
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, changed_reg, slot_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
